// ----- design/assert_macros.svh -----
// Assertion macros used by the allocator top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define AFF_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define AFF_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/aff_pkg.sv -----
// Types and constants of the aligned first-fit block allocator
package aff_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int ADDR_BITS  = 32;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_MERGE = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] alloc_size;
        logic [4:0]  align_log2;
        logic [31:0] free_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] alloc_offset;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] length;
        logic                 free;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

    typedef struct packed {
        logic                 fits;
        logic                 pad_nz;
        logic                 extra_nz;
        logic [ADDR_BITS-1:0] aligned;
        logic [ADDR_BITS-1:0] pad;
        logic [ADDR_BITS-1:0] extra;
        logic [ADDR_BITS-1:0] rem_start;
    } fit_res_t;

endpackage

// ----- design/aff_table.sv -----
// Block table memory: one write port, one registered read port
module aff_table
    import aff_pkg::*;
(
    input  logic             clk,
    input  tbl_wr_t          wr,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [MAX_BLOCKS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/aff_fit.sv -----
// Shared fit unit: alignment, padding, fit test and remainder of one block
module aff_fit
    import aff_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  entry_t               entry,
    input  logic [ADDR_BITS-1:0] size,
    input  logic [4:0]           align_log2,
    output fit_res_t             res
);

    logic [ADDR_BITS:0]   mask;
    logic [ADDR_BITS:0]   aligned_calc;
    logic [ADDR_BITS:0]   aligned_reg;
    logic [ADDR_BITS:0]   aligned_next;
    logic [ADDR_BITS:0]   pad_reg;
    logic [ADDR_BITS:0]   pad_next;
    logic [ADDR_BITS-1:0] len_reg;
    logic [ADDR_BITS-1:0] len_next;
    logic [ADDR_BITS+1:0] need;
    logic [ADDR_BITS+1:0] extra_w;

    assign mask         = ({{ADDR_BITS{1'b0}}, 1'b1} << align_log2) - 1'b1;
    assign aligned_calc = ({1'b0, entry.start} + mask) & ~mask;
    assign aligned_next = load ? aligned_calc : aligned_reg;
    assign pad_next     = load ? (aligned_calc - {1'b0, entry.start}) : pad_reg;
    assign len_next     = load ? entry.length : len_reg;

    always_ff @(posedge clk)
    begin
        aligned_reg <= aligned_next;
        pad_reg     <= pad_next;
        len_reg     <= len_next;
    end

    assign need    = {1'b0, pad_reg} + {2'b00, size};
    assign extra_w = {2'b00, len_reg} - need;

    assign res.fits      = ({2'b00, len_reg} >= need);
    assign res.pad_nz    = (pad_reg != '0);
    assign res.extra_nz  = (extra_w[ADDR_BITS-1:0] != '0);
    assign res.aligned   = aligned_reg[ADDR_BITS-1:0];
    assign res.pad       = pad_reg[ADDR_BITS-1:0];
    assign res.extra     = extra_w[ADDR_BITS-1:0];
    assign res.rem_start = aligned_reg[ADDR_BITS-1:0] + size;

endmodule

// ----- design/aligned_first_fit_block_allocator.sv -----
// Allocate: each scanned block passes S_A_RD, S_A_LD and S_A_CHK, each moved block S_SH_RD and S_SH_WR; up to 3 writes.
// Free: each binary search step passes S_F_RD and S_F_CMP; a final S_F_RD ends the search when no offset matches.
// Merge: S_M_LD0 loads entry 0, then each further block passes S_M_RD and S_M_CMP.
// One command at a time; the next beat is taken once the result is registered.
// A sequencer drives the table's one read port and one write port and the shared fit unit.
// Reset: table holds one free block of length zero, written to entry 0 before the first command is taken.
`include "assert_macros.svh"

module aligned_first_fit_block_allocator
    import aff_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_A_RD   = 5'd1;
    localparam logic [4:0] S_A_LD   = 5'd2;
    localparam logic [4:0] S_A_CHK  = 5'd3;
    localparam logic [4:0] S_SH_RD  = 5'd4;
    localparam logic [4:0] S_SH_WR  = 5'd5;
    localparam logic [4:0] S_W0     = 5'd6;
    localparam logic [4:0] S_W1     = 5'd7;
    localparam logic [4:0] S_W2     = 5'd8;
    localparam logic [4:0] S_F_RD   = 5'd9;
    localparam logic [4:0] S_F_CMP  = 5'd10;
    localparam logic [4:0] S_M_LD0  = 5'd11;
    localparam logic [4:0] S_M_RD   = 5'd12;
    localparam logic [4:0] S_M_CMP  = 5'd13;
    localparam logic [4:0] S_DONE   = 5'd14;

    logic [4:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 init_reg, init_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;
    req_t                 req_reg, req_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [IDX_W-1:0]     wpos_reg, wpos_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic [1:0]           need_reg, need_next;
    logic [1:0]           status_reg, status_next;
    logic [31:0]          offset_reg, offset_next;
    entry_t               cur_reg, cur_next;

    tbl_wr_t              tbl_wr;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    entry_t               rd_data;
    fit_res_t             fit;
    logic                 fit_load;
    logic [1:0]           need_calc;
    logic [CNT_W:0]       count_grow;
    logic [CNT_W-1:0]     mid;
    entry_t               alloc_entry;

    aff_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    aff_fit u_fit (
        .clk        (clk),
        .load       (fit_load),
        .entry      (rd_data),
        .size       (ADDR_BITS'(req_reg.alloc_size)),
        .align_log2 (req_reg.align_log2),
        .res        (fit)
    );

    assign req_stall = (state_reg != S_IDLE) || init_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign fit_load  = (state_reg == S_A_LD);

    assign need_calc   = {1'b0, fit.pad_nz} + {1'b0, fit.extra_nz};
    assign count_grow  = {1'b0, count_reg} + (CNT_W + 1)'(need_calc);
    assign mid         = lo_reg + ((hi_reg - 1'b1 - lo_reg) >> 1);
    assign alloc_entry = '{start: fit.aligned, length: ADDR_BITS'(req_reg.alloc_size),
                           free: 1'b0};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        init_next      = init_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        wpos_next      = wpos_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        j_next         = j_reg;
        need_next      = need_reg;
        status_next    = status_reg;
        offset_next    = offset_reg;
        cur_next       = cur_reg;
        tbl_wr         = '0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (init_reg)
                begin
                    tbl_wr    = '{en: 1'b1, addr: '0, data: '{start: '0, length: '0, free: 1'b1}};
                    init_next = 1'b0;
                end
                else if (req_valid)
                begin
                    req_next    = req;
                    status_next = ST_OK;
                    offset_next = '0;
                    unique case (req.cmd)
                        CMD_ALLOC:
                        begin
                            idx_next   = IDX_W'(count_reg - 1'b1);
                            state_next = S_A_RD;
                        end
                        CMD_FREE:
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = S_F_RD;
                        end
                        CMD_MERGE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_M_LD0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_A_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_A_LD;
            end
            S_A_LD:
            begin
                cur_next   = rd_data;
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (cur_reg.free && fit.fits)
                begin
                    if (count_grow > (CNT_W + 1)'(MAX_BLOCKS))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        count_next  = count_grow[CNT_W-1:0];
                        need_next   = need_calc;
                        offset_next = 32'(fit.aligned);
                        k_next      = IDX_W'(count_reg - 1'b1);
                        if (need_calc == 2'd0 || CNT_W'(idx_reg) + 1'b1 == count_reg)
                        begin
                            state_next = S_W0;
                        end
                        else
                        begin
                            state_next = S_SH_RD;
                        end
                    end
                end
                else if (idx_reg == '0)
                begin
                    status_next = ST_NOFIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_A_RD;
                end
            end
            S_SH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                tbl_wr = '{en: 1'b1, addr: k_reg + IDX_W'(need_reg), data: rd_data};
                if (k_reg == idx_reg + 1'b1)
                begin
                    state_next = S_W0;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_SH_RD;
                end
            end
            S_W0:
            begin
                if (fit.pad_nz)
                begin
                    tbl_wr = '{en: 1'b1, addr: idx_reg,
                               data: '{start: cur_reg.start, length: fit.pad, free: 1'b1}};
                    wpos_next  = idx_reg + 1'b1;
                    state_next = S_W1;
                end
                else
                begin
                    tbl_wr     = '{en: 1'b1, addr: idx_reg, data: alloc_entry};
                    wpos_next  = idx_reg;
                    state_next = fit.extra_nz ? S_W2 : S_DONE;
                end
            end
            S_W1:
            begin
                tbl_wr     = '{en: 1'b1, addr: wpos_reg, data: alloc_entry};
                state_next = fit.extra_nz ? S_W2 : S_DONE;
            end
            S_W2:
            begin
                tbl_wr = '{en: 1'b1, addr: wpos_reg + 1'b1,
                           data: '{start: fit.rem_start, length: fit.extra, free: 1'b1}};
                state_next = S_DONE;
            end
            S_F_RD:
            begin
                if (lo_reg >= hi_reg)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = mid[IDX_W-1:0];
                    rd_en      = 1'b1;
                    rd_addr    = mid[IDX_W-1:0];
                    state_next = S_F_CMP;
                end
            end
            S_F_CMP:
            begin
                if (rd_data.start == ADDR_BITS'(req_reg.free_offset))
                begin
                    tbl_wr = '{en: 1'b1, addr: idx_reg,
                               data: '{start: rd_data.start, length: rd_data.length,
                                       free: 1'b1}};
                    state_next = S_DONE;
                end
                else
                begin
                    if (ADDR_BITS'(req_reg.free_offset) > rd_data.start)
                    begin
                        lo_next = CNT_W'(idx_reg) + 1'b1;
                    end
                    else
                    begin
                        hi_next = CNT_W'(idx_reg);
                    end
                    state_next = S_F_RD;
                end
            end
            S_M_LD0:
            begin
                cur_next   = rd_data;
                j_next     = CNT_W'(1);
                wpos_next  = '0;
                state_next = S_M_RD;
            end
            S_M_RD:
            begin
                if (j_reg >= count_reg)
                begin
                    tbl_wr     = '{en: 1'b1, addr: wpos_reg, data: cur_reg};
                    count_next = CNT_W'(wpos_reg) + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = j_reg[IDX_W-1:0];
                    state_next = S_M_CMP;
                end
            end
            S_M_CMP:
            begin
                if (cur_reg.free && rd_data.free)
                begin
                    cur_next.length = cur_reg.length + rd_data.length;
                end
                else
                begin
                    tbl_wr    = '{en: 1'b1, addr: wpos_reg, data: cur_reg};
                    wpos_next = wpos_reg + 1'b1;
                    cur_next  = rd_data;
                end
                j_next     = j_reg + 1'b1;
                state_next = S_M_RD;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: status_reg, alloc_offset: offset_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration beat rebuilds the table as one free block
        if (cfg_we)
        begin
            tbl_wr     = '{en: 1'b1, addr: '0,
                           data: '{start: '0, length: ADDR_BITS'(cfg_data), free: 1'b1}};
            count_next = CNT_W'(1);
            init_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_W'(1);
            init_reg      <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            init_reg      <= init_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg    <= rsp_next;
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        wpos_reg   <= wpos_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        j_reg      <= j_next;
        need_reg   <= need_next;
        status_reg <= status_next;
        offset_reg <= offset_next;
        cur_reg    <= cur_next;
    end

    `AFF_CHECK(a_count_range, (count_reg != '0) && (count_reg <= CNT_W'(MAX_BLOCKS)), "block count out of range")
    `AFF_IMPLY(a_wr_in_table, tbl_wr.en, CNT_W'(tbl_wr.addr) < count_reg, "table write beyond block count")
    `AFF_IMPLY(a_rsp_from_done, $rose(rsp_valid_reg), $past(state_reg) == S_DONE, "result beat not from done state")
    `AFF_IMPLY(a_busy_after_accept, $past(req_valid && !req_stall), state_reg != S_IDLE, "accepted command left sequencer idle")

endmodule

// ----- sim/aligned_first_fit_block_allocator_tb.sv -----
// Self-checking testbench of the aligned first-fit block allocator
module aligned_first_fit_block_allocator_tb;
    import aff_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 500;
    localparam longint unsigned MASK32 = 64'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    logic cfg_we;
    logic [31:0] cfg_data;

    longint unsigned blk_start [MAX_BLOCKS];
    longint unsigned blk_len [MAX_BLOCKS];
    bit blk_free [MAX_BLOCKS];
    int blk_count;
    longint unsigned pool_size;

    req_t pending_req_q[$];
    rsp_t expected_rsp_q[$];
    int req_gap;
    int rsp_gap;
    bit steady;
    int idle_cycles;
    bit failed;

    aligned_first_fit_block_allocator dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_req(req_t r);
        pending_req_q.insert(pending_req_q.size(), r);
    endfunction

    function automatic void reset_pool(longint unsigned sz);
        pool_size = sz & MASK32;
        blk_start[0] = 0;
        blk_len[0] = pool_size;
        blk_free[0] = 1'b1;
        blk_count = 1;
    endfunction

    function automatic void insert_slot(int pos);
        for (int k = blk_count; k > pos; k--)
        begin
            blk_start[k] = blk_start[k-1];
            blk_len[k] = blk_len[k-1];
            blk_free[k] = blk_free[k-1];
        end
        blk_count++;
    endfunction

    function automatic void delete_slot(int pos);
        for (int k = pos; k + 1 < blk_count; k++)
        begin
            blk_start[k] = blk_start[k+1];
            blk_len[k] = blk_len[k+1];
            blk_free[k] = blk_free[k+1];
        end
        blk_count--;
    endfunction

    function automatic rsp_t allocate_block(longint unsigned sz, int lg);
        longint unsigned align, st, len, aligned, pad, extra;
        int need, pos;
        rsp_t res;
        res = '0;
        res.status = ST_NOFIT;
        align = 64'd1 << lg;
        for (int i = blk_count - 1; i >= 0; i--)
        begin
            if (!blk_free[i])
                continue;
            st = blk_start[i];
            len = blk_len[i];
            aligned = (st + align - 1) & ~(align - 1);
            pad = aligned - st;
            if (len < pad + sz)
                continue;
            extra = len - pad - sz;
            need = (pad > 0) + (extra > 0);
            if (blk_count + need > MAX_BLOCKS)
            begin
                res.status = ST_FULL;
                return res;
            end
            pos = i;
            if (pad > 0)
            begin
                blk_len[i] = pad;
                insert_slot(i + 1);
                pos = i + 1;
                blk_start[pos] = aligned & MASK32;
            end
            blk_len[pos] = sz & MASK32;
            blk_free[pos] = 1'b0;
            if (extra > 0)
            begin
                insert_slot(pos + 1);
                blk_start[pos+1] = (aligned + sz) & MASK32;
                blk_len[pos+1] = extra & MASK32;
                blk_free[pos+1] = 1'b1;
            end
            res.status = ST_OK;
            res.alloc_offset = aligned[31:0];
            return res;
        end
        return res;
    endfunction

    function automatic logic [1:0] release_block(longint unsigned off);
        int lo, hi, mid;
        lo = 0;
        hi = blk_count - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (off == blk_start[mid])
            begin
                blk_free[mid] = 1'b1;
                return ST_OK;
            end
            else if (off > blk_start[mid])
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return ST_NOTFOUND;
    endfunction

    function automatic void coalesce_free();
        int i;
        i = 0;
        while (i + 1 < blk_count)
        begin
            if (blk_free[i] && blk_free[i+1])
            begin
                blk_start[i+1] = blk_start[i];
                blk_len[i+1] = (blk_len[i+1] + blk_len[i]) & MASK32;
                delete_slot(i);
            end
            else
                i++;
        end
    endfunction

    function automatic rsp_t apply_command(req_t r);
        rsp_t res;
        res = '0;
        res.status = ST_OK;
        case (r.cmd)
            CMD_ALLOC: res = allocate_block(longint'(r.alloc_size), int'(r.align_log2));
            CMD_FREE:  res.status = release_block(longint'(r.free_offset));
            CMD_MERGE: coalesce_free();
            default: ;
        endcase
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            req_gap = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_rsp_q.insert(expected_rsp_q.size(), apply_command(req));
            if (!(req_valid && req_stall))
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_req_q.size() > 0)
                begin
                    req <= pending_req_q.pop_front();
                    req_valid <= 1'b1;
                    req_gap = pick_gap();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_gap = 0;
            idle_cycles = 0;
        end
        else
        begin
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("unexpected beat: status %0d offset %h", rsp.status,
                        rsp.alloc_offset);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        failed = 1'b1;
                    end
                    if (rsp.alloc_offset !== want.alloc_offset)
                    begin
                        $error("alloc_offset: expected %h, actual %h", want.alloc_offset,
                            rsp.alloc_offset);
                        failed = 1'b1;
                    end
                end
            end
            if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                rsp_gap = pick_gap();
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("aligned_first_fit_block_allocator regression: fail");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_req_q.size() != 0 || expected_rsp_q.size() != 0 || req_valid);
    endtask

    task automatic write_pool_size(logic [31:0] v);
        wait_drained();
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        reset_pool(longint'(v));
    endtask

    function automatic req_t make_req(logic [1:0] c, logic [31:0] sz, logic [4:0] lg,
        logic [31:0] off);
        req_t r;
        r.cmd = c;
        r.alloc_size = sz;
        r.align_log2 = lg;
        r.free_offset = off;
        return r;
    endfunction

    function automatic req_t random_req(int merge_pct);
        req_t r;
        int k, n;
        longint unsigned lim;
        r.cmd = CMD_ALLOC;
        r.alloc_size = $urandom;
        r.align_log2 = 5'($urandom);
        r.free_offset = $urandom;
        k = $urandom_range(0, 99);
        if (k < merge_pct)
            r.cmd = CMD_MERGE;
        else if (k < merge_pct + 3)
            r.cmd = CMD_RSVD;
        else if (k < merge_pct + 35)
        begin
            r.cmd = CMD_FREE;
            if ($urandom_range(0, 9) < 8)
            begin
                n = $urandom_range(0, blk_count - 1);
                for (int j = 0; j < blk_count; j++)
                    if (!blk_free[(n + j) % blk_count])
                    begin
                        n = (n + j) % blk_count;
                        break;
                    end
                r.free_offset = blk_start[n][31:0];
            end
        end
        else if ($urandom_range(0, 9) < 9)
        begin
            lim = pool_size / 16 + 1;
            if (lim > 64'hFFFF_FFFF)
                lim = 64'hFFFF_FFFF;
            r.alloc_size = $urandom_range(0, int'(lim[31:0]));
            r.align_log2 = 5'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom);
        end
        return r;
    endfunction

    initial
    begin
        logic [31:0] sizes [7];
        int merge_pct, n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        steady = 1'b0;
        reset_pool(0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        queue_req(make_req(CMD_ALLOC, 32'd1, 5'd0, 32'd0));
        queue_req(make_req(CMD_FREE, 32'd0, 5'd0, 32'd0));
        wait_drained();

        write_pool_size(32'h1000);
        queue_req(make_req(CMD_ALLOC, 32'd0, 5'd0, 32'd0));
        queue_req(make_req(CMD_ALLOC, 32'h10, 5'd4, 32'd0));
        queue_req(make_req(CMD_ALLOC, 32'h3, 5'd0, 32'hFFFF_FFFF));
        queue_req(make_req(CMD_ALLOC, 32'h20, 5'd8, 32'd0));
        queue_req(make_req(CMD_ALLOC, 32'hFFFF_FFFF, 5'd31, 32'd0));
        queue_req(make_req(CMD_ALLOC, 32'd1, 5'd31, 32'd0));
        queue_req(make_req(CMD_FREE, 32'd0, 5'd0, 32'd0));
        queue_req(make_req(CMD_FREE, 32'd0, 5'd0, 32'd0));
        queue_req(make_req(CMD_FREE, 32'd0, 5'd0, 32'h100));
        queue_req(make_req(CMD_FREE, 32'd0, 5'd0, 32'h100));
        queue_req(make_req(CMD_FREE, 32'd0, 5'd0, 32'hFFFF_FFFF));
        queue_req(make_req(CMD_FREE, 32'd0, 5'd0, 32'h7));
        queue_req(make_req(CMD_RSVD, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF));
        queue_req(make_req(CMD_MERGE, 32'd0, 5'd0, 32'd0));
        queue_req(make_req(CMD_ALLOC, 32'h1000, 5'd0, 32'd0));
        queue_req(make_req(CMD_ALLOC, 32'd0, 5'd31, 32'd0));
        for (int i = 0; i < 6; i++)
            queue_req(make_req(CMD_ALLOC, 32'd1, 5'd1, 32'd0));
        queue_req(make_req(CMD_MERGE, 32'd0, 5'd0, 32'd0));

        sizes[0] = 32'd0;
        sizes[1] = 32'hFFFF_FFFF;
        sizes[2] = 32'h1000;
        sizes[3] = 32'h100;
        sizes[4] = $urandom;
        sizes[5] = 32'd1;
        sizes[6] = 32'h8000_0000;
        for (int p = 0; p < 7; p++)
        begin
            write_pool_size(sizes[p]);
            merge_pct = (p % 2) ? 3 : 15;
            n = 0;
            while (n < 86)
            begin
                steady = ($urandom_range(0, 4) == 0);
                for (int b = $urandom_range(1, 6); b > 0 && n < 86; b--)
                begin
                    queue_req(random_req(merge_pct));
                    n++;
                end
                wait_drained();
            end
        end
        steady = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && expected_rsp_q.size() == 0)
            $display("aligned_first_fit_block_allocator regression: pass");
        else
            $display("aligned_first_fit_block_allocator regression: fail");
        $finish;
    end
endmodule
